>>> rtl/ldq_pkg.sv
// ----------------------------------------------------------------------------
// Linked id deque package
// Shared sizes and the command encoding of the linked id deque.
// ----------------------------------------------------------------------------
package ldq_pkg;

   localparam int NUM_IDS   = 16;
   localparam int IDX_W     = $clog2(NUM_IDS);
   localparam int PROC_ID_W = 4;
   localparam int CMD_W     = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ_TAIL = 3'd0,
      CMD_ENQ_HEAD = 3'd1,
      CMD_DEQ_HEAD = 3'd2,
      CMD_DEQ_TAIL = 3'd3,
      CMD_REMOVE   = 3'd4,
      CMD_TEST     = 3'd5
   } cmd_type;

   typedef logic [IDX_W-1:0] idx_type;

endpackage

>>> rtl/ldq_if.sv
// ----------------------------------------------------------------------------
// Linked id deque channels
// Valid/ready channels for the command items and the result items.
// ----------------------------------------------------------------------------
interface ldq_req_if;
   import ldq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [PROC_ID_W-1:0] proc_id;

   modport source (output valid, output cmd, output proc_id, input ready);
   modport sink   (input valid, input cmd, input proc_id, output ready);
endinterface

interface ldq_rsp_if;
   import ldq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 status;
   logic [PROC_ID_W-1:0] taken_id;
   logic                 is_member;
   logic [PROC_ID_W-1:0] head_id;
   logic                 is_empty;

   modport source (output valid, output status, output taken_id, output is_member,
                   output head_id, output is_empty, input ready);
   modport sink   (input valid, input status, input taken_id, input is_member,
                   input head_id, input is_empty, output ready);
endinterface

>>> rtl/linked_id_deque.sv
// ----------------------------------------------------------------------------
// Linked id deque
// Double-ended queue of process ids held as a doubly linked list.
// ----------------------------------------------------------------------------
// The block takes one command item per cycle and returns one result item per
// command: the command is held in an input register, the list update (a read
// of one next and one previous link entry and at most one write to each link
// table) is done in a single pass, and the result sits in an output register
// until it is taken. A stalled result only stops the input side once the
// input register is also full. Link entries of ids never linked hold no
// defined value, and none is needed: their values are used only for ids on
// the list. Membership bits clear at reset.
// ----------------------------------------------------------------------------
module linked_id_deque (
   input logic     clock,
   input logic     reset,
   ldq_req_if.sink   req_ch,
   ldq_rsp_if.source rsp_ch
);
   import ldq_pkg::*;

   localparam int CMP_W = PROC_ID_W + 1;

   // Input register.
   logic                 in_valid_ff;
   cmd_type              cmd_ff;
   logic [PROC_ID_W-1:0] id_ff;

   // List state.
   idx_type              next_link_ff [NUM_IDS];
   idx_type              prev_link_ff [NUM_IDS];
   logic [NUM_IDS-1:0]   member_ff, member_in;
   idx_type              head_ff, head_in;
   idx_type              tail_ff, tail_in;
   logic                 empty_ff, empty_in;

   // Result register.
   logic                 rsp_valid_ff;
   logic                 status_ff, status_in;
   logic [PROC_ID_W-1:0] taken_ff, taken_in;
   logic                 member_out_ff, member_out_in;
   logic [PROC_ID_W-1:0] head_out_ff;
   logic                 empty_out_ff;

   logic    advance;
   logic    id_ok;
   idx_type idx;
   logic    held;
   idx_type rd_idx;
   idx_type next_rd, prev_rd;
   logic    do_unlink;
   logic    next_we, prev_we;
   idx_type next_waddr, next_wdata, prev_waddr, prev_wdata;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   assign id_ok = {1'b0, id_ff} < CMP_W'(NUM_IDS);
   assign idx   = id_ff[IDX_W-1:0];
   assign held  = member_ff[idx];

   // Each link table is read at a single address: the end being dequeued or
   // the named id.
   always_comb begin
      unique case (cmd_ff)
         CMD_DEQ_HEAD: rd_idx = head_ff;
         CMD_DEQ_TAIL: rd_idx = tail_ff;
         default:      rd_idx = idx;
      endcase
   end

   assign next_rd = next_link_ff[rd_idx];
   assign prev_rd = prev_link_ff[rd_idx];

   always_comb begin
      status_in     = 1'b1;
      taken_in      = '0;
      member_out_in = 1'b0;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      member_in     = member_ff;
      do_unlink     = 1'b0;
      next_we       = 1'b0;
      prev_we       = 1'b0;
      next_waddr    = idx;
      next_wdata    = idx;
      prev_waddr    = idx;
      prev_wdata    = idx;

      unique case (cmd_ff)
         CMD_ENQ_TAIL, CMD_ENQ_HEAD: begin
            if (id_ok && !held) begin
               status_in      = 1'b0;
               member_in[idx] = 1'b1;
               next_we        = 1'b1;
               prev_we        = 1'b1;
               if (empty_ff) begin
                  // First id links to itself in both directions.
                  head_in  = idx;
                  tail_in  = idx;
                  empty_in = 1'b0;
               end else if (cmd_ff == CMD_ENQ_TAIL) begin
                  next_waddr = tail_ff;
                  prev_wdata = tail_ff;
                  tail_in    = idx;
               end else begin
                  prev_waddr = head_ff;
                  next_wdata = head_ff;
                  head_in    = idx;
               end
            end
         end
         CMD_DEQ_HEAD, CMD_DEQ_TAIL: begin
            if (!empty_ff) begin
               status_in = 1'b0;
               taken_in  = PROC_ID_W'(rd_idx);
               do_unlink = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (id_ok && held) begin
               status_in = 1'b0;
               taken_in  = PROC_ID_W'(rd_idx);
               do_unlink = 1'b1;
            end
         end
         CMD_TEST: begin
            if (id_ok) begin
               status_in     = 1'b0;
               member_out_in = held;
            end
         end
         default: begin
         end
      endcase

      if (do_unlink) begin
         member_in[rd_idx] = 1'b0;
         if (head_ff == tail_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b1;
         end else if (rd_idx == head_ff) begin
            head_in = next_rd;
         end else if (rd_idx == tail_ff) begin
            tail_in = prev_rd;
         end else begin
            // Interior id: its neighbors point past it.
            next_we    = 1'b1;
            next_waddr = prev_rd;
            next_wdata = next_rd;
            prev_we    = 1'b1;
            prev_waddr = next_rd;
            prev_wdata = prev_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         member_ff    <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            member_ff    <= member_in;
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            empty_ff     <= empty_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         cmd_ff <= cmd_type'(req_ch.cmd);
         id_ff  <= req_ch.proc_id;
      end
      if (advance) begin
         status_ff     <= status_in;
         taken_ff      <= taken_in;
         member_out_ff <= member_out_in;
         head_out_ff   <= empty_in ? '0 : PROC_ID_W'(head_in);
         empty_out_ff  <= empty_in;
         if (next_we) begin
            next_link_ff[next_waddr] <= next_wdata;
         end
         if (prev_we) begin
            prev_link_ff[prev_waddr] <= prev_wdata;
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.taken_id  = taken_ff;
   assign rsp_ch.is_member = member_out_ff;
   assign rsp_ch.head_id   = head_out_ff;
   assign rsp_ch.is_empty  = empty_out_ff;

endmodule
